// ===== rtl/ccomp_pkg.sv =====
package ccomp_pkg;

  localparam int LANDSCAPE_WIDTH  = 448;
  localparam int LANDSCAPE_HEIGHT = 368;
  localparam int PANEL_ROW_PIXELS = 368;

  localparam int DIV_STEPS  = 16;
  localparam int SQRT_STEPS = 24;

  localparam logic [2:0] REG_START_X      = 3'd0;
  localparam logic [2:0] REG_START_Y      = 3'd1;
  localparam logic [2:0] REG_START_RADIUS = 3'd2;
  localparam logic [2:0] REG_END_X        = 3'd3;
  localparam logic [2:0] REG_END_Y        = 3'd4;
  localparam logic [2:0] REG_END_RADIUS   = 3'd5;
  localparam logic [2:0] REG_TARGET_GRAY  = 3'd6;

  // sideband that rides along the divider
  typedef struct packed {
    logic               vld;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic [7:0]         cur;
    logic               onscreen;
    logic [17:0]        pidx;
    logic               t_zero;
    logic               t_one;
  } div_side_t;

  // sideband that rides along the square root
  typedef struct packed {
    logic        vld;
    logic [16:0] rad;
    logic [7:0]  cur;
    logic        onscreen;
    logic [17:0] pidx;
  } sqrt_side_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [15:0] quo;
  } div_step_t;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] res;
  } sqrt_step_t;

  // one restoring division step: one quotient bit
  function automatic div_step_t div_step(input logic [33:0] rem, input logic [15:0] quo,
                                         input logic [33:0] len2);
    logic [34:0] dbl;
    logic        ge;
    div_step_t   s;
    dbl   = {rem, 1'b0};
    ge    = (dbl >= {1'b0, len2});
    s.rem = ge ? 34'(dbl - {1'b0, len2}) : dbl[33:0];
    s.quo = {quo[14:0], ge};
    return s;
  endfunction

  // one digit of the bitwise square root
  function automatic sqrt_step_t sqrt_step(input logic [47:0] x, input logic [47:0] res,
                                           input logic [47:0] b);
    logic [47:0] sum;
    sqrt_step_t  s;
    sum = res + b;
    if (x >= sum) begin
      s.x   = x - sum;
      s.res = (res >> 1) + b;
    end else begin
      s.x   = x;
      s.res = res >> 1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/ccomp_div.sv =====
module ccomp_div import ccomp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [35:0] in_dot,
  input  logic [33:0]        in_len2,
  input  div_side_t          in_side,
  output logic [16:0]        out_t16,
  output div_side_t          out_side
);

  logic [33:0] rem_r  [1:DIV_STEPS];
  logic [15:0] quo_r  [1:DIV_STEPS];
  logic [33:0] len_r  [1:DIV_STEPS];
  div_side_t   side_r [1:DIV_STEPS];
  div_step_t   step_c [1:DIV_STEPS];

  logic [16:0] t16_r;
  div_side_t   fin_side_r;
  logic        rnd_c;

  always_comb begin
    step_c[1] = div_step(in_dot[33:0], 16'd0, in_len2);
    for (int k = 2; k <= DIV_STEPS; k++) begin
      step_c[k] = div_step(rem_r[k-1], quo_r[k-1], len_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
        side_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      rem_r[1]  <= step_c[1].rem;
      quo_r[1]  <= step_c[1].quo;
      len_r[1]  <= in_len2;
      side_r[1] <= in_side;
      for (int k = 2; k <= DIV_STEPS; k++) begin
        rem_r[k]  <= step_c[k].rem;
        quo_r[k]  <= step_c[k].quo;
        len_r[k]  <= len_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // round to nearest: add half the divisor to the remainder
  assign rnd_c = ({1'b0, rem_r[DIV_STEPS]} + {2'b0, len_r[DIV_STEPS][33:1]})
                 >= {1'b0, len_r[DIV_STEPS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_side_r.vld <= 1'b0;
    end else if (en) begin
      fin_side_r <= side_r[DIV_STEPS];
      if (side_r[DIV_STEPS].t_zero) begin
        t16_r <= 17'd0;
      end else if (side_r[DIV_STEPS].t_one) begin
        t16_r <= 17'h10000;
      end else begin
        t16_r <= {1'b0, quo_r[DIV_STEPS]} + 17'(rnd_c);
      end
    end
  end

  assign out_t16  = t16_r;
  assign out_side = fin_side_r;

endmodule

// ===== rtl/ccomp_sqrt.sv =====
module ccomp_sqrt import ccomp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [47:0] in_n,
  input  sqrt_side_t  in_side,
  output logic [24:0] out_dist,
  output sqrt_side_t  out_side
);

  logic [47:0] x_r    [1:SQRT_STEPS];
  logic [47:0] res_r  [1:SQRT_STEPS];
  sqrt_side_t  side_r [1:SQRT_STEPS];
  sqrt_step_t  step_c [1:SQRT_STEPS];

  logic [24:0] dist_r;
  sqrt_side_t  fin_side_r;

  always_comb begin
    step_c[1] = sqrt_step(in_n, 48'd0, 48'd1 << (2 * SQRT_STEPS - 2));
    for (int k = 2; k <= SQRT_STEPS; k++) begin
      step_c[k] = sqrt_step(x_r[k-1], res_r[k-1], 48'd1 << (2 * (SQRT_STEPS - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        side_r[k].vld <= 1'b0;
      end
      fin_side_r.vld <= 1'b0;
    end else if (en) begin
      x_r[1]    <= step_c[1].x;
      res_r[1]  <= step_c[1].res;
      side_r[1] <= in_side;
      for (int k = 2; k <= SQRT_STEPS; k++) begin
        x_r[k]    <= step_c[k].x;
        res_r[k]  <= step_c[k].res;
        side_r[k] <= side_r[k-1];
      end
      // round up when the remainder exceeds the root
      fin_side_r <= side_r[SQRT_STEPS];
      dist_r     <= {1'b0, res_r[SQRT_STEPS][23:0]}
                    + 25'(x_r[SQRT_STEPS] > res_r[SQRT_STEPS]);
    end
  end

  assign out_dist = dist_r;
  assign out_side = fin_side_r;

endmodule

// ===== rtl/capsule_coverage_compositor.sv =====
// Anti-aliased capsule coverage with min compositing, one pixel per item.
// Configuration: write segment end points, end radii and target gray through
// cfg_valid/cfg_index/cfg_wdata while no pixel is in flight; cfg_ready is
// always high and writes to unknown indexes are dropped.
// Input: in_valid with pixel_x, pixel_y and the stored gray; an item is taken
// at a clock edge where in_valid is high and in_stall is low.
// Output: out_valid with write_enable, new_gray and panel_index; new_gray and
// panel_index are zero when write_enable is low.
// From acceptance to out_valid an item passes 3 setup stages, a
// 17-stage divider (one quotient bit per stage, then rounding), 4 projection
// stages, a 25-stage square root (one root bit per stage, then rounding) and
// 2 blending stages. Throughput is one item per cycle while the output does not stall.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all configuration registers to zero and empties
// the pipeline.
module capsule_coverage_compositor import ccomp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [10:0] in_pixel_x,
  input  logic signed [10:0] in_pixel_y,
  input  logic [7:0]         in_current_gray,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_enable,
  output logic [7:0]         out_new_gray,
  output logic [17:0]        out_panel_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic signed [15:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [11:0]        start_radius_r, end_radius_r;
  logic [7:0]         target_gray_r;

  logic               en;
  logic signed [16:0] abx_c, aby_c;
  logic signed [12:0] rdiff_c;
  logic signed [14:0] px_c, py_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r      <= '0;
      start_y_r      <= '0;
      start_radius_r <= '0;
      end_x_r        <= '0;
      end_y_r        <= '0;
      end_radius_r   <= '0;
      target_gray_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_X:      start_x_r      <= cfg_wdata;
        REG_START_Y:      start_y_r      <= cfg_wdata;
        REG_START_RADIUS: start_radius_r <= cfg_wdata[11:0];
        REG_END_X:        end_x_r        <= cfg_wdata;
        REG_END_Y:        end_y_r        <= cfg_wdata;
        REG_END_RADIUS:   end_radius_r   <= cfg_wdata[11:0];
        REG_TARGET_GRAY:  target_gray_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign abx_c   = 17'(end_x_r) - 17'(start_x_r);
  assign aby_c   = 17'(end_y_r) - 17'(start_y_r);
  assign rdiff_c = $signed({1'b0, end_radius_r}) - $signed({1'b0, start_radius_r});

  // hold every stage while a result waits at the output
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // pixel centre in 1/16 pixel
  assign px_c = {in_pixel_x, 4'b1000};
  assign py_c = {in_pixel_y, 4'b1000};

  // stage 1: offsets from the segment start
  logic               s1_vld_r;
  logic signed [17:0] s1_ax_r, s1_ay_r;
  logic signed [10:0] s1_lx_r, s1_ly_r;
  logic [7:0]         s1_cur_r;

  // stage 2: products
  logic               s2_vld_r;
  logic signed [35:0] s2_px_r, s2_py_r;
  logic signed [33:0] s2_lx_r, s2_ly_r;
  logic signed [17:0] s2_ax_r, s2_ay_r;
  logic [7:0]         s2_cur_r;
  logic               s2_onscreen_r;
  logic [17:0]        s2_pidx_r;

  // stage 3: dot product and squared length
  logic               s3_vld_r;
  logic signed [35:0] s3_dot_r;
  logic [33:0]        s3_len2_r;
  logic signed [17:0] s3_ax_r, s3_ay_r;
  logic [7:0]         s3_cur_r;
  logic               s3_onscreen_r;
  logic [17:0]        s3_pidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r  <= 18'(px_c) - 18'(start_x_r);
      s1_ay_r  <= 18'(py_c) - 18'(start_y_r);
      s1_lx_r  <= in_pixel_x;
      s1_ly_r  <= in_pixel_y;
      s1_cur_r <= in_current_gray;

      s2_px_r       <= s1_ax_r * abx_c;
      s2_py_r       <= s1_ay_r * aby_c;
      s2_lx_r       <= abx_c * abx_c;
      s2_ly_r       <= aby_c * aby_c;
      s2_ax_r       <= s1_ax_r;
      s2_ay_r       <= s1_ay_r;
      s2_cur_r      <= s1_cur_r;
      s2_onscreen_r <= !s1_lx_r[10] && !s1_ly_r[10]
                       && (11'(s1_lx_r) < 11'(LANDSCAPE_WIDTH))
                       && (11'(s1_ly_r) < 11'(LANDSCAPE_HEIGHT));
      s2_pidx_r     <= 18'(s1_lx_r) * 18'(PANEL_ROW_PIXELS)
                       + 18'(PANEL_ROW_PIXELS - 1) - 18'(s1_ly_r);

      s3_dot_r      <= s2_px_r + s2_py_r;
      s3_len2_r     <= 34'(s2_lx_r + s2_ly_r);
      s3_ax_r       <= s2_ax_r;
      s3_ay_r       <= s2_ay_r;
      s3_cur_r      <= s2_cur_r;
      s3_onscreen_r <= s2_onscreen_r;
      s3_pidx_r     <= s2_pidx_r;
    end
  end

  div_side_t   dv_in_side, dv_out_side;
  logic [16:0] dv_t16;

  always_comb begin
    dv_in_side.vld      = s3_vld_r;
    dv_in_side.ax       = s3_ax_r;
    dv_in_side.ay       = s3_ay_r;
    dv_in_side.cur      = s3_cur_r;
    dv_in_side.onscreen = s3_onscreen_r;
    dv_in_side.pidx     = s3_pidx_r;
    dv_in_side.t_zero   = (s3_len2_r == 34'd0) || (s3_dot_r <= 36'sd0);
    dv_in_side.t_one    = s3_dot_r >= $signed({2'b00, s3_len2_r});
  end

  ccomp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_dot   (s3_dot_r),
    .in_len2  (s3_len2_r),
    .in_side  (dv_in_side),
    .out_t16  (dv_t16),
    .out_side (dv_out_side)
  );

  // stage 4: scale the segment and radius slope by t
  logic               s4_vld_r;
  logic signed [35:0] s4_mx_r, s4_my_r;
  logic signed [31:0] s4_mr_r;
  logic signed [17:0] s4_ax_r, s4_ay_r;
  logic [7:0]         s4_cur_r;
  logic               s4_onscreen_r;
  logic [17:0]        s4_pidx_r;

  // stage 5: offsets to the projected point, interpolated radius
  logic               s5_vld_r;
  logic signed [23:0] s5_dx_r, s5_dy_r;
  logic [16:0]        s5_rad_r;
  logic [7:0]         s5_cur_r;
  logic               s5_onscreen_r;
  logic [17:0]        s5_pidx_r;

  // stage 6: squares
  logic               s6_vld_r;
  logic signed [47:0] s6_sqx_r, s6_sqy_r;
  logic [16:0]        s6_rad_r;
  logic [7:0]         s6_cur_r;
  logic               s6_onscreen_r;
  logic [17:0]        s6_pidx_r;

  // stage 7: squared distance
  logic               s7_vld_r;
  logic [47:0]        s7_n_r;
  logic [16:0]        s7_rad_r;
  logic [7:0]         s7_cur_r;
  logic               s7_onscreen_r;
  logic [17:0]        s7_pidx_r;

  logic signed [35:0] vx_c, vy_c;
  logic signed [31:0] rv_c;

  assign vx_c = (36'(s4_ax_r) <<< 16) - s4_mx_r + 36'sd2048;
  assign vy_c = (36'(s4_ay_r) <<< 16) - s4_my_r + 36'sd2048;
  assign rv_c = $signed({4'b0, start_radius_r, 16'b0}) + s4_mr_r + 32'sd2048;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= dv_out_side.vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mx_r       <= abx_c * $signed({1'b0, dv_t16});
      s4_my_r       <= aby_c * $signed({1'b0, dv_t16});
      s4_mr_r       <= rdiff_c * $signed({1'b0, dv_t16});
      s4_ax_r       <= dv_out_side.ax;
      s4_ay_r       <= dv_out_side.ay;
      s4_cur_r      <= dv_out_side.cur;
      s4_onscreen_r <= dv_out_side.onscreen;
      s4_pidx_r     <= dv_out_side.pidx;

      s5_dx_r       <= vx_c[35:12];
      s5_dy_r       <= vy_c[35:12];
      s5_rad_r      <= rv_c[28:12];
      s5_cur_r      <= s4_cur_r;
      s5_onscreen_r <= s4_onscreen_r;
      s5_pidx_r     <= s4_pidx_r;

      s6_sqx_r      <= s5_dx_r * s5_dx_r;
      s6_sqy_r      <= s5_dy_r * s5_dy_r;
      s6_rad_r      <= s5_rad_r;
      s6_cur_r      <= s5_cur_r;
      s6_onscreen_r <= s5_onscreen_r;
      s6_pidx_r     <= s5_pidx_r;

      s7_n_r        <= 48'(s6_sqx_r + s6_sqy_r);
      s7_rad_r      <= s6_rad_r;
      s7_cur_r      <= s6_cur_r;
      s7_onscreen_r <= s6_onscreen_r;
      s7_pidx_r     <= s6_pidx_r;
    end
  end

  sqrt_side_t  sq_in_side, sq_out_side;
  logic [24:0] sq_dist;

  always_comb begin
    sq_in_side.vld      = s7_vld_r;
    sq_in_side.rad      = s7_rad_r;
    sq_in_side.cur      = s7_cur_r;
    sq_in_side.onscreen = s7_onscreen_r;
    sq_in_side.pidx     = s7_pidx_r;
  end

  ccomp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_n     (s7_n_r),
    .in_side  (sq_in_side),
    .out_dist (sq_dist),
    .out_side (sq_out_side)
  );

  // stage 8: coverage
  logic        s8_vld_r;
  logic        s8_wr_ok_r;
  logic [8:0]  s8_cov_r;
  logic [7:0]  s8_cur_r;
  logic [17:0] s8_pidx_r;

  logic signed [26:0] cov_c;
  assign cov_c = 27'sd128 - $signed({2'b0, sq_dist}) + $signed({10'b0, sq_out_side.rad});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= sq_out_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_wr_ok_r <= sq_out_side.onscreen && (cov_c > 27'sd0);
      s8_cov_r   <= (cov_c > 27'sd256) ? 9'd256 : cov_c[8:0];
      s8_cur_r   <= sq_out_side.cur;
      s8_pidx_r  <= sq_out_side.pidx;
    end
  end

  // stage 9: blend toward white, min compositing
  logic [17:0] ink_sum_c;
  logic [7:0]  ink_c;
  logic        we_c;

  assign ink_sum_c = 18'(target_gray_r) * 18'(s8_cov_r)
                     + 18'(10'd256 - 10'(s8_cov_r)) * 18'd255 + 18'd128;
  assign ink_c     = ink_sum_c[15:8];
  assign we_c      = s8_wr_ok_r && (ink_c < s8_cur_r);

  logic        out_we_r;
  logic [7:0]  out_gray_r;
  logic [17:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_we_r   <= we_c;
      out_gray_r <= we_c ? ink_c : 8'd0;
      out_idx_r  <= we_c ? s8_pidx_r : 18'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_new_gray     = out_gray_r;
  assign out_panel_index  = out_idx_r;

`ifndef SYNTH
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_we_r |-> out_gray_r == 8'd0 && out_idx_r == 18'd0)
    else $error("result without write carries non-zero payload");

  a_ink_darker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_we_r |-> out_gray_r != 8'hFF)
    else $error("written ink is white");

  a_no_cov_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    en && s8_vld_r && !s8_wr_ok_r |=> out_valid_r && !out_we_r)
    else $error("uncovered or off-screen pixel produced a write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid straight after reset");
`endif

endmodule
